FILE: src/fit_policy_block_allocator_macros.svh
// Assertion macros shared by the allocator checker.
// Needs a clock named clk and a reset named rst in the scope of use.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define FPBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define FPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fpba_pkg.sv
// Shared constants, codes and types of the fit-policy block allocator.
// No dependencies; most src files refer to it by scoped names, and the sim files import it.
package fpba_pkg;

  localparam int NUM_BLOCKS = 8;
  localparam int SIZE_WIDTH = 16;
  localparam int IDX_W      = 3;
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int POL_W      = 2;
  localparam int BIU_W      = 4;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic REG_FIT_POLICY    = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  localparam logic [BIU_W-1:0] BIU_RESET = 4'd8;

  typedef struct packed {
    logic [POL_W-1:0] fit_policy;
    logic [BIU_W-1:0] blocks_in_use;
  } cfg_t;

  typedef struct packed {
    logic                  en;
    logic [IDX_W-1:0]      addr;
    logic [SIZE_WIDTH-1:0] data;
  } store_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

endpackage

FILE: src/fpba_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on fpba_pkg for field widths.
interface fpba_req_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [fpba_pkg::IDX_W-1:0]     block_index;
  logic [fpba_pkg::SIZE_WIDTH-1:0] size_value;

  modport source (output valid, output operation, output block_index,
                  output size_value, input ready);
  modport sink (input valid, input operation, input block_index,
                input size_value, output ready);
endinterface

interface fpba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       granted;
  logic [fpba_pkg::IDX_W-1:0] chosen_block;

  modport source (output valid, output granted, output chosen_block, input ready);
  modport sink (input valid, input granted, input chosen_block, output ready);
endinterface

FILE: src/fit_policy_block_allocator.sv
// Fit-policy block allocator: keeps the free size of each block and grants
// allocate requests by first, best or worst fit. A load transaction gives no
// response. An allocate transaction searches up to N blocks, where N is the
// number of blocks searched (blocks_in_use, capped at the block count); first
// fit stops at the first block that fits. The single compare unit reads one
// entry of the size RAM per cycle during the scan; the accept, the scan and
// the charge of the chosen block follow in that order, and the charge holds
// while an earlier response still waits. The request channel is ready only
// between allocations; a finished response waits in its own register, and
// new transactions are taken while it waits.
// Depends on fpba_pkg, fpba_if, fpba_cfg, fpba_store and fpba_scan.
module fit_policy_block_allocator (
  input  logic                          clk,
  input  logic                          rst,
  fpba_req_if.sink                      req,
  fpba_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpba_pkg::ADDR_W-1:0]   paddr,
  input  logic [fpba_pkg::DATA_W-1:0]   pwdata,
  output logic [fpba_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  fpba_pkg::cfg_t                  cfg;
  fpba_pkg::store_wr_t             wr;
  logic [fpba_pkg::IDX_W-1:0]      rd_addr;
  logic [fpba_pkg::SIZE_WIDTH-1:0] rd_data;

  fpba_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fpba_store #(
    .WIDTH (fpba_pkg::SIZE_WIDTH),
    .DEPTH (fpba_pkg::NUM_BLOCKS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fpba_scan u_scan (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (req.valid),
    .in_ready         (req.ready),
    .in_operation     (req.operation),
    .in_block_index   (req.block_index),
    .in_size_value    (req.size_value),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .wr               (wr),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .out_granted      (rsp.granted),
    .out_chosen_block (rsp.chosen_block)
  );

endmodule

FILE: src/fpba_cfg.sv
// APB-style configuration registers: fit policy and number of blocks searched.
// Depends on fpba_pkg.
module fpba_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpba_pkg::ADDR_W-1:0]   paddr,
  input  logic [fpba_pkg::DATA_W-1:0]   pwdata,
  output logic [fpba_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output fpba_pkg::cfg_t                cfg
);

  fpba_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];
  assign cfg     = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.fit_policy    <= fpba_pkg::POL_FIRST;
      cfg_q.blocks_in_use <= fpba_pkg::BIU_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        fpba_pkg::REG_FIT_POLICY:    cfg_q.fit_policy    <= pwdata[fpba_pkg::POL_W-1:0];
        fpba_pkg::REG_BLOCKS_IN_USE: cfg_q.blocks_in_use <= pwdata[fpba_pkg::BIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      fpba_pkg::REG_FIT_POLICY:
        prdata = fpba_pkg::DATA_W'(cfg_q.fit_policy);
      fpba_pkg::REG_BLOCKS_IN_USE:
        prdata = fpba_pkg::DATA_W'(cfg_q.blocks_in_use);
      default:
        prdata = '0;
    endcase
  end

endmodule

FILE: src/fpba_store.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; entries hold nothing defined until written.
module fpba_store #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/fpba_scan.sv
// Sequencer and shared compare unit: writes loads, scans one block per cycle,
// picks the block under the fit policy, charges it and registers the response.
// Depends on fpba_pkg.
module fpba_scan (
  input  logic                              clk,
  input  logic                              rst,
  input  fpba_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [fpba_pkg::IDX_W-1:0]        in_block_index,
  input  logic [fpba_pkg::SIZE_WIDTH-1:0]   in_size_value,
  output logic [fpba_pkg::IDX_W-1:0]        rd_addr,
  input  logic [fpba_pkg::SIZE_WIDTH-1:0]   rd_data,
  output fpba_pkg::store_wr_t               wr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_granted,
  output logic [fpba_pkg::IDX_W-1:0]        out_chosen_block
);

  fpba_pkg::state_t                state, state_next;
  logic [fpba_pkg::SIZE_WIDTH-1:0] req_size, req_size_next;
  logic [fpba_pkg::POL_W-1:0]      policy, policy_next;
  logic [fpba_pkg::CNT_W-1:0]      limit, limit_next;
  logic [fpba_pkg::CNT_W-1:0]      cnt, cnt_next;
  logic                            found, found_next;
  logic [fpba_pkg::IDX_W-1:0]      best, best_next;
  logic [fpba_pkg::SIZE_WIDTH-1:0] best_size, best_size_next;
  logic                            rsp_valid, rsp_valid_next;
  logic                            rsp_granted, rsp_granted_next;
  logic [fpba_pkg::IDX_W-1:0]      rsp_block, rsp_block_next;

  logic [fpba_pkg::CNT_W-1:0]      cfg_limit;
  logic                            fits;
  logic                            take;
  logic                            first_fit;
  logic                            last;

  // Saturate the searched count at the number of blocks.
  assign cfg_limit = (int'(cfg.blocks_in_use) > fpba_pkg::NUM_BLOCKS) ?
                     fpba_pkg::CNT_W'(fpba_pkg::NUM_BLOCKS) :
                     fpba_pkg::CNT_W'(cfg.blocks_in_use);

  // Address the entry needed next cycle; the store read is registered.
  assign rd_addr   = cnt_next[fpba_pkg::IDX_W-1:0];
  assign first_fit = (policy != fpba_pkg::POL_BEST) && (policy != fpba_pkg::POL_WORST);
  assign fits      = rd_data >= req_size;
  assign take      = fits && (!found ||
                     ((policy == fpba_pkg::POL_BEST)  && (rd_data < best_size)) ||
                     ((policy == fpba_pkg::POL_WORST) && (rd_data > best_size)));
  assign last      = ((cnt + 1'b1) == limit) || (fits && first_fit);

  always_comb begin
    state_next       = state;
    req_size_next    = req_size;
    policy_next      = policy;
    limit_next       = limit;
    cnt_next         = cnt;
    found_next       = found;
    best_next        = best;
    best_size_next   = best_size;
    rsp_valid_next   = rsp_valid && !out_ready;
    rsp_granted_next = rsp_granted;
    rsp_block_next   = rsp_block;
    in_ready         = 1'b0;
    wr.en            = 1'b0;
    wr.addr          = in_block_index;
    wr.data          = in_size_value;

    unique case (state)
      fpba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_operation == fpba_pkg::OP_LOAD) begin
            // Drop loads aimed past the last block.
            wr.en = (int'(in_block_index) < fpba_pkg::NUM_BLOCKS);
          end else begin
            req_size_next  = in_size_value;
            policy_next    = cfg.fit_policy;
            limit_next     = cfg_limit;
            cnt_next       = '0;
            found_next     = 1'b0;
            best_next      = '0;
            best_size_next = '0;
            state_next     = (cfg_limit == '0) ? fpba_pkg::ST_FINISH : fpba_pkg::ST_SCAN;
          end
        end
      end
      fpba_pkg::ST_SCAN: begin
        if (take) begin
          found_next     = 1'b1;
          best_next      = cnt[fpba_pkg::IDX_W-1:0];
          best_size_next = rd_data;
        end
        cnt_next = cnt + 1'b1;
        if (last) begin
          state_next = fpba_pkg::ST_FINISH;
        end
      end
      fpba_pkg::ST_FINISH: begin
        // Hold until the response register is free.
        if (!rsp_valid || out_ready) begin
          wr.en            = found;
          wr.addr          = best;
          wr.data          = best_size - req_size;
          rsp_valid_next   = 1'b1;
          rsp_granted_next = found;
          rsp_block_next   = found ? best : '0;
          state_next       = fpba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fpba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fpba_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
      found     <= 1'b0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      found     <= found_next;
      cnt       <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    req_size    <= req_size_next;
    policy      <= policy_next;
    limit       <= limit_next;
    best        <= best_next;
    best_size   <= best_size_next;
    rsp_granted <= rsp_granted_next;
    rsp_block   <= rsp_block_next;
  end

  assign out_valid        = rsp_valid;
  assign out_granted      = rsp_granted;
  assign out_chosen_block = rsp_block;

endmodule

FILE: src/fpba_checker.sv
// Port-level checks of the fit-policy block allocator, bound to the top level.
// Depends on fpba_pkg and the assertion macros header.
`include "fit_policy_block_allocator_macros.svh"

module fpba_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              req_operation,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic                              rsp_granted,
  input logic [fpba_pkg::IDX_W-1:0]        rsp_chosen_block
);

  logic req_fire;

  assign req_fire = req_valid && req_ready;

  // A stalled response keeps its payload.
  `FPBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_granted) && $stable(rsp_chosen_block), "response changed while stalled")

  // A refused request reports block zero.
  `FPBA_ASSERT_NOW(a_deny_zero, rsp_valid && !rsp_granted, rsp_chosen_block == '0, "denied response names a nonzero block")

  // A load never raises a response.
  `FPBA_ASSERT_NEXT(a_load_silent, req_fire && (req_operation == fpba_pkg::OP_LOAD) && !rsp_valid, !rsp_valid, "load produced a response")

  // An allocation closes the request channel while it runs.
  `FPBA_ASSERT_NEXT(a_alloc_busy, req_fire && (req_operation == fpba_pkg::OP_ALLOC), !req_ready, "request taken during an allocation")

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_operation    (req.operation),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_granted      (rsp.granted),
  .rsp_chosen_block (rsp.chosen_block)
);

FILE: sim/fit_policy_block_allocator_checker.sv
// Checker for the fit-policy block allocator: mirrors block sizes and config,
// predicts each grant and compares it with the response channel.
// Depends on fpba_pkg and the request/response interfaces in fpba_if.
module fit_policy_block_allocator_checker (
  input  logic                        clk,
  input  logic                        rst,
  fpba_req_if                         req_mon,
  fpba_rsp_if                         rsp_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [fpba_pkg::ADDR_W-1:0] paddr,
  input  logic [fpba_pkg::DATA_W-1:0] pwdata,
  output int                          fail_count,
  output int                          outstanding
);
  import fpba_pkg::*;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] chosen_block;
  } grant_t;

  logic [SIZE_WIDTH-1:0] free_size [NUM_BLOCKS];
  logic [POL_W-1:0]      policy = POL_FIRST;
  logic [BIU_W-1:0]      span   = BIU_RESET;
  grant_t                grant_q [$];
  int                    errors = 0;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t allocator mismatch: %s", $time, msg);
  endtask

  // Pick a block under the current policy and charge the request to it.
  function automatic grant_t predict_grant(input logic [SIZE_WIDTH-1:0] need);
    grant_t g;
    int     limit;
    int     pick;
    bit     found;
    g     = '0;
    pick  = 0;
    found = 1'b0;
    limit = (span > NUM_BLOCKS) ? NUM_BLOCKS : int'(span);
    for (int j = 0; j < limit; j++) begin
      if (free_size[j] < need) continue;
      if (!found) begin
        found = 1'b1;
        pick  = j;
        // spare policy code behaves as first fit
        if (policy != POL_BEST && policy != POL_WORST) break;
      end else if (policy == POL_BEST && free_size[j] < free_size[pick]) begin
        pick = j;
      end else if (policy == POL_WORST && free_size[j] > free_size[pick]) begin
        pick = j;
      end
    end
    if (found) begin
      free_size[pick] = free_size[pick] - need;
      g.granted       = 1'b1;
      g.chosen_block  = pick[IDX_W-1:0];
    end
    return g;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (rst) begin
      policy = POL_FIRST;
      span   = BIU_RESET;
      grant_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_FIT_POLICY, 2'b00}) begin
          policy = pwdata[POL_W-1:0];
        end else if (paddr == {REG_BLOCKS_IN_USE, 2'b00}) begin
          span = pwdata[BIU_W-1:0];
        end
      end
      // responses first: a request taken at this edge cannot answer yet
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (grant_q.size() == 0) begin
          report_mismatch($sformatf("response with nothing pending (granted %0b block %0d)",
                                    rsp_mon.granted, rsp_mon.chosen_block));
        end else begin
          want = grant_q.pop_front();
          if (rsp_mon.granted !== want.granted)
            report_mismatch($sformatf("granted %0b, want %0b",
                                      rsp_mon.granted, want.granted));
          if (rsp_mon.chosen_block !== want.chosen_block)
            report_mismatch($sformatf("chosen_block %0d, want %0d",
                                      rsp_mon.chosen_block, want.chosen_block));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.operation == OP_LOAD) begin
          if (req_mon.block_index < NUM_BLOCKS)
            free_size[req_mon.block_index] = req_mon.size_value;
        end else begin
          grant_q.push_back(predict_grant(req_mon.size_value));
        end
      end
    end
    fail_count  <= errors;
    outstanding <= grant_q.size();
  end

endmodule

FILE: sim/fit_policy_block_allocator_tb.sv
// Top of the fit-policy block allocator testbench: clock, reset, stimulus,
// config writes and the verdict. Depends on fpba_pkg, fpba_if and the checker.
module fit_policy_block_allocator_tb;
  import fpba_pkg::*;

  localparam int               STALL_LIMIT     = 4000;
  localparam int               RANDOM_PHASES   = 12;
  localparam int               ITEMS_PER_PHASE = 86;
  localparam logic [POL_W-1:0] POL_SPARE       = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_POLICY    = {REG_FIT_POLICY, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SPAN      = {REG_BLOCKS_IN_USE, 2'b00};

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int fail_count;
  int outstanding;

  logic [POL_W-1:0] phase_policy [RANDOM_PHASES] = '{POL_FIRST, POL_BEST, POL_WORST,
    POL_SPARE, POL_BEST, POL_WORST, POL_FIRST, POL_BEST, POL_WORST, POL_SPARE,
    POL_BEST, POL_WORST};
  logic [BIU_W-1:0] phase_span [RANDOM_PHASES] = '{4'd8, 4'd8, 4'd8, 4'd8, 4'd1,
    4'd15, 4'd3, 4'd5, 4'd0, 4'd12, 4'd6, 4'd8};

  fpba_req_if req_ch();
  fpba_rsp_if rsp_ch();

  fit_policy_block_allocator u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fit_policy_block_allocator_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial forever #2 clk = ~clk;

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("fit_policy_block_allocator_tb: errors");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [SIZE_WIDTH-1:0] size);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= op;
    req_ch.block_index <= idx;
    req_ch.size_value  <= size;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Hold requests until every pending grant is back, then let a load settle.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [POL_W-1:0] pol, input logic [BIU_W-1:0] span);
    drain_responses();
    write_reg(ADDR_POLICY, DATA_W'(pol));
    write_reg(ADDR_SPAN, DATA_W'(span));
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 86;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 86;
      end
      default: begin
        send_idle_pct  = 12;
        recv_stall_pct = 12;
      end
    endcase
  endtask

  // Multiples of 256 make equal sizes common, so ties get exercised.
  function automatic logic [SIZE_WIDTH-1:0] load_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SIZE_WIDTH'($urandom_range(1, 4) * 256);
      4:       return SIZE_WIDTH'($urandom);
      default: return SIZE_WIDTH'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic logic [SIZE_WIDTH-1:0] request_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SIZE_WIDTH'($urandom);
      2:       return '1;
      3:       return SIZE_WIDTH'($urandom_range(1, 4) * 128);
      default: return SIZE_WIDTH'($urandom_range(1, 800));
    endcase
  endfunction

  initial begin
    logic op;
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.operation   <= OP_LOAD;
    req_ch.block_index <= '0;
    req_ch.size_value  <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // load every block before any search touches it
    send_item(OP_LOAD, 3'd0, 16'd0);
    send_item(OP_LOAD, 3'd1, 16'd500);
    send_item(OP_LOAD, 3'd2, 16'd300);
    send_item(OP_LOAD, 3'd3, 16'd500);
    send_item(OP_LOAD, 3'd4, 16'd300);
    send_item(OP_LOAD, 3'd5, 16'd1000);
    send_item(OP_LOAD, 3'd6, 16'd200);
    send_item(OP_LOAD, 3'd7, 16'hFFFF);
    // first fit: zero request, full-size request, nothing fits, plain fit
    send_item(OP_ALLOC, 3'd0, 16'd0);
    send_item(OP_ALLOC, 3'd7, 16'hFFFF);
    send_item(OP_ALLOC, 3'd5, 16'd2000);
    send_item(OP_ALLOC, 3'd2, 16'd250);
    configure(POL_BEST, 4'd8);
    send_item(OP_ALLOC, 3'd1, 16'd250);
    send_item(OP_ALLOC, 3'd6, 16'd300);
    configure(POL_WORST, 4'd8);
    send_item(OP_ALLOC, 3'd3, 16'd100);
    send_item(OP_LOAD, 3'd5, 16'd500);
    send_item(OP_ALLOC, 3'd4, 16'd10);
    // spare policy code with an oversized span
    configure(POL_SPARE, 4'd15);
    send_item(OP_ALLOC, 3'd0, 16'd100);
    configure(POL_BEST, 4'd0);
    send_item(OP_ALLOC, 3'd0, 16'd0);
    configure(POL_WORST, 4'd1);
    send_item(OP_ALLOC, 3'd0, 16'd0);
    send_item(OP_ALLOC, 3'd0, 16'd1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure(phase_policy[p], phase_span[p]);
      set_idling(p);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        op = ($urandom_range(0, 99) < 35) ? OP_LOAD : OP_ALLOC;
        send_item(op, IDX_W'($urandom_range(0, 7)),
                  (op == OP_LOAD) ? load_size() : request_size());
        if ($urandom_range(0, 59) == 0) drain_responses();
      end
    end

    drain_responses();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("fit_policy_block_allocator_tb: clean");
    end else begin
      $display("fit_policy_block_allocator_tb: errors");
    end
    $finish;
  end

endmodule
